// ===== hdl/q2e_pkg.sv =====
// q2e_pkg: types, widths and constants for the quaternion to Euler angle pipeline.
// Used by every module under hdl; depends on nothing.
`default_nettype none
package q2e_pkg;

    localparam int W_Q     = 16;
    localparam int W_OP    = 35;
    localparam int W_C     = 40;
    localparam int W_Z     = 28;
    localparam int SQ_BITS = 31;
    localparam int W_REM   = 63;
    localparam int W_SQ    = 64;

    localparam int HALF_PI_Q24 = 26353589;
    localparam int HALF_PI_Q13 = 12868;
    localparam int PI_Q13      = 25736;
    localparam int ONE_Q30     = 1 << 30;

    typedef struct packed {
        logic signed [W_Q-1:0] qx;
        logic signed [W_Q-1:0] qy;
        logic signed [W_Q-1:0] qz;
        logic signed [W_Q-1:0] qw;
    } t_in;

    typedef struct packed {
        logic signed [W_Q-1:0] angle_x;
        logic signed [W_Q-1:0] angle_y;
        logic signed [W_Q-1:0] angle_z;
        logic                  singular;
    } t_out;

    typedef struct packed {
        logic signed [W_OP-1:0] s;
        logic                   sing;
        logic signed [W_OP-1:0] ay_y;
        logic signed [W_OP-1:0] ay_x;
        logic signed [W_OP-1:0] az_y;
        logic signed [W_OP-1:0] az_x;
    } t_side;

    function automatic logic signed [W_Z-1:0] atan_q24(input int i);
        logic signed [W_Z-1:0] v;
        case (i)
            0:       v = W_Z'(13176795);
            1:       v = W_Z'(7778716);
            2:       v = W_Z'(4110060);
            3:       v = W_Z'(2086331);
            4:       v = W_Z'(1047214);
            5:       v = W_Z'(524117);
            6:       v = W_Z'(262123);
            7:       v = W_Z'(131069);
            8:       v = W_Z'(65536);
            9:       v = W_Z'(32768);
            10:      v = W_Z'(16384);
            11:      v = W_Z'(8192);
            12:      v = W_Z'(4096);
            13:      v = W_Z'(2048);
            14:      v = W_Z'(1024);
            15:      v = W_Z'(512);
            16:      v = W_Z'(256);
            17:      v = W_Z'(128);
            18:      v = W_Z'(64);
            19:      v = W_Z'(32);
            20:      v = W_Z'(16);
            21:      v = W_Z'(8);
            22:      v = W_Z'(4);
            23:      v = W_Z'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/quaternion_to_euler.sv =====
// Quaternion to Euler angles: Q1.15 quaternion in, three Q3.13 angles and a singular flag out.
// Path from accept to o_out_valid: three front stages, 32 square root stages, the CORDIC lanes.
// Throughput: one transaction per cycle while o_in_stall is low; a two-entry output
// register and skid stage take the result while the far side stalls. Synchronous active-low
// reset clears all valid bits.
`default_nettype none
module quaternion_to_euler import q2e_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int CL = CORDIC_STEPS + 2;

    logic                  en;
    logic                  f_valid, q_valid;
    t_side                 f_side, q_side;
    logic [W_SQ-1:0]       f_sq;
    logic [SQ_BITS-1:0]    q_root;
    logic signed [W_Q-1:0] ang_x, ang_y, ang_z;
    logic                  r_tv   [0:CL-1];
    logic                  r_tsg  [0:CL-1];
    logic                  r_tneg [0:CL-1];
    t_out                  p_data, r_od, n_od, r_sd, n_sd;
    logic                  r_ov, n_ov, r_sv, n_sv, take;

    assign en         = ~r_sv;
    assign o_in_stall = r_sv;

    q2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_sq    (f_sq)
    );

    q2e_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_sq    (f_sq),
        .o_valid (q_valid),
        .o_side  (q_side),
        .o_root  (q_root)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_lane_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (q_side.s),
        .i_x     (W_OP'({1'b0, q_root})),
        .o_angle (ang_x)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_lane_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (q_side.ay_y),
        .i_x     (q_side.ay_x),
        .o_angle (ang_y)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_lane_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (q_side.az_y),
        .i_x     (q_side.az_x),
        .o_angle (ang_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CL; i++) begin
                r_tv[i] <= 1'b0;
            end
        end else if (en) begin
            r_tv[0] <= q_valid;
            for (int i = 1; i < CL; i++) begin
                r_tv[i] <= r_tv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tsg[0]  <= q_side.sing;
            r_tneg[0] <= q_side.s[W_OP-1];
            for (int i = 1; i < CL; i++) begin
                r_tsg[i]  <= r_tsg[i-1];
                r_tneg[i] <= r_tneg[i-1];
            end
        end
    end

    always_comb begin
        p_data.angle_x  = ang_x;
        if (r_tsg[CL-1]) begin
            p_data.angle_x = r_tneg[CL-1] ? -W_Q'(HALF_PI_Q13) : W_Q'(HALF_PI_Q13);
        end
        p_data.angle_y  = ang_y;
        p_data.angle_z  = ang_z;
        p_data.singular = r_tsg[CL-1];
    end

    assign take = r_ov & ~i_out_stall;

    always_comb begin
        n_ov = r_ov;
        n_od = r_od;
        n_sv = r_sv;
        n_sd = r_sd;
        if (r_sv) begin
            if (!r_ov || take) begin
                n_ov = 1'b1;
                n_od = r_sd;
                n_sv = 1'b0;
            end
        end else if (r_tv[CL-1]) begin
            if (!r_ov || take) begin
                n_ov = 1'b1;
                n_od = p_data;
            end else begin
                n_sv = 1'b1;
                n_sd = p_data;
            end
        end else if (take) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_sd <= n_sd;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid entry held with empty output register");

    a_singular_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_od.singular) |->
        (r_od.angle_x == W_Q'(HALF_PI_Q13) || r_od.angle_x == -W_Q'(HALF_PI_Q13)))
        else $error("singular result without clamped X angle");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_od.angle_y <= W_Q'(PI_Q13) && r_od.angle_y >= -W_Q'(PI_Q13)))
        else $error("Y angle beyond pi");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !take) |=> r_sv) else $error("skid entry dropped while output stalled");
`endif

endmodule
`default_nettype wire

// ===== hdl/q2e_front.sv =====
// q2e_front: products, atan2 operands, singular test and square of the asin argument.
// Three register stages; depends on q2e_pkg.
`default_nettype none
module q2e_front import q2e_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_in              i_data,
    output logic             o_valid,
    output t_side            o_side,
    output logic [W_SQ-1:0]  o_sq
);

    logic signed [2*W_Q-1:0] r_wx, r_yz, r_xz, r_wy, r_xy, r_zw, r_xx, r_yy, r_zz;
    logic                    r_v1, r_v2, r_v3;
    t_side                   r_side2, r_side3, n_side2;
    logic        [W_SQ-1:0]  r_sq;
    logic signed [31:0]      s32;

    always_comb begin
        n_side2.s    = (W_OP'(r_wx) - W_OP'(r_yz)) <<< 1;
        n_side2.sing = (n_side2.s >= W_OP'(ONE_Q30)) || (n_side2.s <= -W_OP'(ONE_Q30));
        n_side2.ay_y = (W_OP'(r_xz) + W_OP'(r_wy)) <<< 1;
        n_side2.ay_x = W_OP'(ONE_Q30) - ((W_OP'(r_yy) + W_OP'(r_xx)) <<< 1);
        n_side2.az_y = (W_OP'(r_xy) + W_OP'(r_zw)) <<< 1;
        n_side2.az_x = W_OP'(ONE_Q30) - ((W_OP'(r_xx) + W_OP'(r_zz)) <<< 1);
    end

    assign s32 = r_side2.s[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx    <= (2*W_Q)'(i_data.qw) * (2*W_Q)'(i_data.qx);
            r_yz    <= (2*W_Q)'(i_data.qy) * (2*W_Q)'(i_data.qz);
            r_xz    <= (2*W_Q)'(i_data.qx) * (2*W_Q)'(i_data.qz);
            r_wy    <= (2*W_Q)'(i_data.qw) * (2*W_Q)'(i_data.qy);
            r_xy    <= (2*W_Q)'(i_data.qx) * (2*W_Q)'(i_data.qy);
            r_zw    <= (2*W_Q)'(i_data.qz) * (2*W_Q)'(i_data.qw);
            r_xx    <= (2*W_Q)'(i_data.qx) * (2*W_Q)'(i_data.qx);
            r_yy    <= (2*W_Q)'(i_data.qy) * (2*W_Q)'(i_data.qy);
            r_zz    <= (2*W_Q)'(i_data.qz) * (2*W_Q)'(i_data.qz);
            r_side2 <= n_side2;
            r_sq    <= W_SQ'(s32 * s32);
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_side3;
    assign o_sq    = r_sq;

endmodule
`default_nettype wire

// ===== hdl/q2e_sqrt.sv =====
// q2e_sqrt: pipelined restoring square root of 2^60 minus the square, one root bit a stage.
// Carries the operand bundle alongside; depends on q2e_pkg.
`default_nettype none
module q2e_sqrt import q2e_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_side              i_side,
    input  logic [W_SQ-1:0]    i_sq,
    output logic               o_valid,
    output t_side              o_side,
    output logic [SQ_BITS-1:0] o_root
);

    logic [W_REM-1:0]   r_rem  [0:SQ_BITS];
    logic [SQ_BITS-1:0] r_root [0:SQ_BITS];
    t_side              r_side [0:SQ_BITS];
    logic               r_v    [0:SQ_BITS];
    logic [W_REM-1:0]   n_inc  [0:SQ_BITS-1];
    logic [W_SQ-1:0]    n_rad;

    assign n_rad = (W_SQ'(1) << 60) - i_sq;

    always_comb begin
        for (int j = 0; j < SQ_BITS; j++) begin
            n_inc[j] = (W_REM'(r_root[j]) << (SQ_BITS - j))
                     + (W_REM'(1) << (2 * (SQ_BITS - 1 - j)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= SQ_BITS; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 0; j < SQ_BITS; j++) begin
                r_v[j+1] <= r_v[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= W_REM'(n_rad[60:0]);
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int j = 0; j < SQ_BITS; j++) begin
                r_side[j+1] <= r_side[j];
                if (r_rem[j] >= n_inc[j]) begin
                    r_rem[j+1]  <= r_rem[j] - n_inc[j];
                    r_root[j+1] <= r_root[j] | (SQ_BITS'(1) << (SQ_BITS - 1 - j));
                end else begin
                    r_rem[j+1]  <= r_rem[j];
                    r_root[j+1] <= r_root[j];
                end
            end
        end
    end

    assign o_valid = r_v[SQ_BITS];
    assign o_side  = r_side[SQ_BITS];
    assign o_root  = r_root[SQ_BITS];

endmodule
`default_nettype wire

// ===== hdl/q2e_cordic.sv =====
// q2e_cordic: one pipelined vectoring CORDIC lane giving atan2 in Q3.13, clamped to +-pi.
// Quadrant pre-rotation, STEPS iteration stages, rounding stage; depends on q2e_pkg.
`default_nettype none
module q2e_cordic import q2e_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [W_OP-1:0] i_y,
    input  logic signed [W_OP-1:0] i_x,
    output logic signed [W_Q-1:0]  o_angle
);

    logic signed [W_C-1:0] r_x [0:STEPS];
    logic signed [W_C-1:0] r_y [0:STEPS];
    logic signed [W_Z-1:0] r_z [0:STEPS];
    logic                  r_zero [0:STEPS];
    logic signed [W_C-1:0] n_x, n_y, ex, ey;
    logic signed [W_Z-1:0] n_z, n_sum, n_res, n_clamp;
    logic signed [W_Q-1:0] r_angle;

    assign ex = W_C'(i_x);
    assign ey = W_C'(i_y);

    always_comb begin
        n_x = ex;
        n_y = ey;
        n_z = '0;
        if (ex < 0) begin
            if (ey >= 0) begin
                n_x = ey;
                n_y = -ex;
                n_z = W_Z'(HALF_PI_Q24);
            end else begin
                n_x = -ey;
                n_y = ex;
                n_z = -W_Z'(HALF_PI_Q24);
            end
        end
    end

    always_comb begin
        n_sum   = r_z[STEPS] + W_Z'(1024);
        n_res   = n_sum >>> 11;
        n_clamp = n_res;
        if (n_res > W_Z'(PI_Q13)) begin
            n_clamp = W_Z'(PI_Q13);
        end else if (n_res < -W_Z'(PI_Q13)) begin
            n_clamp = -W_Z'(PI_Q13);
        end
        if (r_zero[STEPS]) begin
            n_clamp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_zero[0] <= (ex == 0) && (ey == 0);
            for (int i = 0; i < STEPS; i++) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][W_C-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q24(i);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q24(i);
                end
            end
            r_angle <= W_Q'(n_clamp);
        end
    end

    assign o_angle = r_angle;

endmodule
`default_nettype wire
